>>> rtl/tssag_pkg.sv
package tssag_pkg;

  // tile geometry
  localparam int unsigned TILE_BYTES = 2048;
  localparam int unsigned TILE_ROWS  = 32;

  // stream word widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 72;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // shared divider widths
  localparam int unsigned DIV_N_W   = 16;
  localparam int unsigned DIV_D_W   = 7;
  localparam int unsigned DIV_CNT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_COUNT       = 3'd0,
    CFG_STATE_TILES      = 3'd1,
    CFG_PAGE_COLUMNS     = 3'd2,
    CFG_CHUNK_COUNT      = 3'd3,
    CFG_STATE_ROW_BASE   = 3'd4,
    CFG_TOKENS_PER_SEQ   = 3'd5,
    CFG_TOKENS_PER_CHUNK = 3'd6
  } cfg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_CHECK    = 7'b0000010,
    ST_DIV_SQ   = 7'b0000100,
    ST_DIV_TILE = 7'b0001000,
    ST_DIV_HS   = 7'b0010000,
    ST_MAC      = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } seq_state_e;

  typedef enum logic [3:0] {
    OP_HOFF  = 4'd0,
    OP_X     = 4'd1,
    OP_FPAGE = 4'd2,
    OP_START = 4'd3,
    OP_TG    = 4'd4,
    OP_RPAGE = 4'd5,
    OP_HS    = 4'd6,
    OP_R0    = 4'd7,
    OP_COL   = 4'd8,
    OP_SPAGE = 4'd9
  } mac_op_e;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quot;
    logic [DIV_D_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/tssag_div.sv
// Restoring divider, one quotient bit per cycle.
module tssag_div import tssag_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_N_W-1:0]   quot_q, quot_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_D_W-1:0]   dvs_q, dvs_d;

  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W+1:0]   diff;
  logic                 ge;

  // one trial subtraction
  assign shifted = {rem_q, quot_q[DIV_N_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[DIV_D_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quot_d = {quot_q[DIV_N_W-2:0], ge};
      rem_d  = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
      cnt_d  = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> rtl/tiled_state_scatter_address_gen_core.sv
// Write-burst generator for scattering 32x32 bf16 tiles (four 16x16 faces) into a
// tiled destination. One word in, then the block is busy until its last burst is
// loaded into the output register. A small sequencer drives one shared
// multiply-add unit (one operation per cycle) and one restoring divider.
// Output region: accept, check, one division (instance / head count), then 3 or 4
// multiply-adds, then one whole-tile burst on the aligned path, or two bursts per
// valid token row (up to 64). State region: three divisions (instance, tile index,
// row offset), 4 multiply-adds, then 64 bursts. A word that produces no burst
// frees the block once it fails the request check or has no valid rows.
// Bursts leave at one per cycle while m_axis_tready stays high.
module tiled_state_scatter_address_gen_core import tssag_pkg::*; #(
  parameter int unsigned MAX_STATE_TILES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: instance_req[15:0], chunk[31:16], tile_index[35:32], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func
  input  logic                  s_axis_tuser,
  // burst words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: src_offset[14:0], dest_page[46:15], dest_offset[57:47],
  //        burst_bytes[69:58], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tlast: last_burst
  output logic                  m_axis_tlast
);

  localparam int unsigned ST_W = $clog2(MAX_STATE_TILES + 1);

  // configuration registers
  logic [6:0]  head_count_q;
  logic [2:0]  state_tiles_q;
  logic [10:0] page_columns_q;
  logic [15:0] chunk_count_q;
  logic [23:0] state_row_base_q;
  logic [15:0] tokens_per_seq_q;
  logic [5:0]  tokens_per_chunk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_count_q       <= 7'd1;
      state_tiles_q      <= 3'd2;
      page_columns_q     <= 11'd4;
      chunk_count_q      <= 16'd1;
      state_row_base_q   <= 24'd0;
      tokens_per_seq_q   <= 16'd32;
      tokens_per_chunk_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEAD_COUNT:       head_count_q       <= cfg_data_i[6:0];
        CFG_STATE_TILES:      state_tiles_q      <= cfg_data_i[2:0];
        CFG_PAGE_COLUMNS:     page_columns_q     <= cfg_data_i[10:0];
        CFG_CHUNK_COUNT:      chunk_count_q      <= cfg_data_i[15:0];
        CFG_STATE_ROW_BASE:   state_row_base_q   <= cfg_data_i[23:0];
        CFG_TOKENS_PER_SEQ:   tokens_per_seq_q   <= cfg_data_i[15:0];
        CFG_TOKENS_PER_CHUNK: tokens_per_chunk_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [6:0]        hc;
  logic [ST_W-1:0]   st_n;
  logic [ST_W+4:0]   s_n;
  logic [2*ST_W-1:0] st_sq;

  assign hc    = (head_count_q == 7'd0) ? 7'd1 : head_count_q;
  assign st_n  = (32'(state_tiles_q) > MAX_STATE_TILES) ? ST_W'(MAX_STATE_TILES)
                                                        : ST_W'(state_tiles_q);
  assign s_n   = {st_n, 5'b00000};
  assign st_sq = (2*ST_W)'(st_n) * (2*ST_W)'(st_n);

  // sequencer and work registers
  seq_state_e      state_q, state_d;
  mac_op_e         op_q, op_d;
  logic            func_q, func_d;
  logic [15:0]     inst_q, inst_d;
  logic [15:0]     cc_q, cc_d;
  logic [3:0]      tile_q, tile_d;
  logic [15:0]     sq_q, sq_d;
  logic [6:0]      h_q, h_d;
  logic [3:0]      it_q, it_d;
  logic [ST_W-1:0] jt_q, jt_d;
  logic [15:0]     q_q, q_d;
  logic [6:0]      rm_q, rm_d;
  logic [9:0]      hoff_q, hoff_d;
  logic [9:0]      colp_q, colp_d;
  logic [32:0]     tmp_q, tmp_d;
  logic [31:0]     pg_q, pg_d;
  logic [4:0]      rr_q, rr_d;
  logic [4:0]      lr_q, lr_d;
  logic            fc_q, fc_d;
  logic [5:0]      rows_q, rows_d;
  logic            whole_q, whole_d;

  // output register
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_last_q, out_last_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tssag_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared multiply-add: a * b + c
  logic [31:0] mac_a;
  logic [15:0] mac_b;
  logic [31:0] mac_c;
  logic [47:0] mac_sum;
  logic [32:0] mac_res;

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    case (op_q)
      OP_HOFF: begin
        mac_a = 32'(h_q);
        mac_b = 16'(st_n);
        mac_c = 32'(tile_q);
      end
      OP_X: begin
        mac_a = 32'(sq_q);
        mac_b = chunk_count_q;
        mac_c = 32'(cc_q);
      end
      OP_FPAGE: begin
        mac_a = tmp_q[31:0];
        mac_b = 16'(page_columns_q);
        mac_c = 32'(hoff_q);
      end
      OP_START: begin
        mac_a = 32'(cc_q);
        mac_b = 16'(tokens_per_chunk_q);
      end
      OP_TG: begin
        mac_a = 32'(sq_q);
        mac_b = tokens_per_seq_q;
        mac_c = tmp_q[31:0];
      end
      OP_RPAGE: begin
        mac_a = 32'(tmp_q[31:5]);
        mac_b = 16'(page_columns_q);
        mac_c = 32'(hoff_q);
      end
      OP_HS: begin
        mac_a = 32'(h_q);
        mac_b = 16'(s_n);
        mac_c = 32'({it_q, 5'b00000});
      end
      OP_R0: begin
        mac_a = 32'(sq_q);
        mac_b = 16'(s_n);
        mac_c = 32'(state_row_base_q) + 32'(q_q);
      end
      OP_COL: begin
        mac_a = 32'(rm_q);
        mac_b = 16'(st_n);
        mac_c = 32'(jt_q);
      end
      OP_SPAGE: begin
        mac_a = 32'(tmp_q[31:5]);
        mac_b = 16'(page_columns_q);
      end
      default: ;
    endcase
  end

  assign mac_sum = 48'(mac_a) * 48'(mac_b) + 48'(mac_c);
  assign mac_res = mac_sum[32:0];

  // valid row count of a chunk, from the chunk start held in tmp_q
  logic [15:0] row_diff;
  logic [5:0]  row_lim;
  logic [5:0]  row_cnt;

  assign row_diff = tokens_per_seq_q - tmp_q[15:0];
  assign row_lim  = (tokens_per_chunk_q > 6'd32) ? 6'd32 : tokens_per_chunk_q;
  always_comb begin
    row_cnt = '0;
    if (tmp_q[21:0] < 22'(tokens_per_seq_q)) begin
      row_cnt = (row_diff < 16'(row_lim)) ? row_diff[5:0] : row_lim;
    end
  end

  // request checks and burst fields
  logic        req_ok;
  logic        fast_path;
  logic        out_load;
  logic        emit_last;
  logic [14:0] emit_src;
  logic [31:0] emit_page;
  logic [10:0] emit_doff;
  logic [11:0] emit_bytes;

  assign req_ok = func_q ? ((32'(tile_q) < 32'(st_sq)) &&
                            ((17'(cc_q) + 17'd1) == 17'(chunk_count_q)))
                         : (32'(tile_q) < 32'(st_n));
  assign fast_path = (tokens_per_seq_q[4:0] == 5'd0) && (tokens_per_chunk_q == 6'd32);

  assign out_load  = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);
  assign emit_last = whole_q || (fc_q && (6'(lr_q) == rows_q - 6'd1));
  assign emit_src  = whole_q ? {tile_q, 11'd0} : {tile_q, lr_q[4], fc_q, lr_q[3:0], 5'd0};
  assign emit_page = pg_q + 32'(colp_q);
  assign emit_doff = whole_q ? 11'd0 : {rr_q[4], fc_q, rr_q[3:0], 5'd0};
  assign emit_bytes = whole_q ? 12'(TILE_BYTES) : 12'd32;

  assign s_axis_tready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    func_d     = func_q;
    inst_d     = inst_q;
    cc_d       = cc_q;
    tile_d     = tile_q;
    sq_d       = sq_q;
    h_d        = h_q;
    it_d       = it_q;
    jt_d       = jt_q;
    q_d        = q_q;
    rm_d       = rm_q;
    hoff_d     = hoff_q;
    colp_d     = colp_q;
    tmp_d      = tmp_q;
    pg_d       = pg_q;
    rr_d       = rr_q;
    lr_d       = lr_q;
    fc_d       = fc_q;
    rows_d     = rows_q;
    whole_d    = whole_q;
    div_req    = '0;
    m_valid_d  = (m_valid_q && !m_axis_tready) ? 1'b1 : 1'b0;
    out_data_d = out_data_q;
    out_last_d = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          func_d  = s_axis_tuser;
          inst_d  = s_axis_tdata[15:0];
          cc_d    = s_axis_tdata[31:16];
          tile_d  = s_axis_tdata[35:32];
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (req_ok) begin
          div_req.start    = 1'b1;
          div_req.dividend = inst_q;
          div_req.divisor  = hc;
          state_d          = ST_DIV_SQ;
        end else begin
          state_d = ST_IDLE;
        end
      end

      // sequence and head
      ST_DIV_SQ: begin
        if (div_rsp.done) begin
          sq_d = div_rsp.quot;
          h_d  = div_rsp.rem;
          if (func_q) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_N_W'(tile_q);
            div_req.divisor  = DIV_D_W'(st_n);
            state_d          = ST_DIV_TILE;
          end else begin
            op_d    = OP_HOFF;
            state_d = ST_MAC;
          end
        end
      end

      // tile row and column inside the head
      ST_DIV_TILE: begin
        if (div_rsp.done) begin
          it_d    = div_rsp.quot[3:0];
          jt_d    = div_rsp.rem[ST_W-1:0];
          op_d    = OP_HS;
          state_d = ST_MAC;
        end
      end

      // first interleaved row: quotient and remainder by head count
      ST_DIV_HS: begin
        if (div_rsp.done) begin
          q_d     = div_rsp.quot;
          rm_d    = div_rsp.rem;
          op_d    = OP_R0;
          state_d = ST_MAC;
        end
      end

      ST_MAC: begin
        case (op_q)
          OP_HOFF: begin
            hoff_d = mac_res[9:0];
            op_d   = fast_path ? OP_X : OP_START;
          end
          OP_X: begin
            tmp_d = mac_res;
            op_d  = OP_FPAGE;
          end
          OP_FPAGE: begin
            pg_d    = mac_res[31:0];
            colp_d  = '0;
            whole_d = 1'b1;
            rows_d  = 6'd1;
            lr_d    = '0;
            fc_d    = 1'b0;
            state_d = ST_EMIT;
          end
          OP_START: begin
            tmp_d = mac_res;
            op_d  = OP_TG;
          end
          OP_TG: begin
            rows_d = row_cnt;
            tmp_d  = mac_res;
            op_d   = OP_RPAGE;
          end
          OP_RPAGE: begin
            pg_d    = mac_res[31:0];
            rr_d    = tmp_q[4:0];
            colp_d  = '0;
            whole_d = 1'b0;
            lr_d    = '0;
            fc_d    = 1'b0;
            state_d = (rows_q == 6'd0) ? ST_IDLE : ST_EMIT;
          end
          OP_HS: begin
            div_req.start    = 1'b1;
            div_req.dividend = mac_res[DIV_N_W-1:0];
            div_req.divisor  = hc;
            state_d          = ST_DIV_HS;
          end
          OP_R0: begin
            tmp_d = mac_res;
            op_d  = OP_COL;
          end
          OP_COL: begin
            colp_d = mac_res[9:0];
            op_d   = OP_SPAGE;
          end
          OP_SPAGE: begin
            pg_d    = mac_res[31:0];
            rr_d    = tmp_q[4:0];
            whole_d = 1'b0;
            rows_d  = 6'(TILE_ROWS);
            lr_d    = '0;
            fc_d    = 1'b0;
            state_d = ST_EMIT;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_EMIT: begin
        if (out_load) begin
          m_valid_d  = 1'b1;
          out_data_d = {2'b00, emit_bytes, emit_doff, emit_page, emit_src};
          out_last_d = emit_last;
          fc_d       = ~fc_q;
          if (emit_last) begin
            state_d = ST_IDLE;
          end else if (fc_q) begin
            lr_d = lr_q + 5'd1;
            // step the destination row: every token row, or on head wrap
            if (!func_q || ((8'(rm_q) + 8'd1) == 8'(hc))) begin
              rr_d = rr_q + 5'd1;
              if (rr_q == 5'd31) begin
                pg_d = pg_q + 32'(page_columns_q);
              end
            end
            if (func_q) begin
              if ((8'(rm_q) + 8'd1) == 8'(hc)) begin
                rm_d   = '0;
                colp_d = 10'(jt_q);
              end else begin
                rm_d   = rm_q + 7'd1;
                colp_d = colp_q + 10'(st_n);
              end
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_HOFF;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    inst_q     <= inst_d;
    cc_q       <= cc_d;
    tile_q     <= tile_d;
    sq_q       <= sq_d;
    h_q        <= h_d;
    it_q       <= it_d;
    jt_q       <= jt_d;
    q_q        <= q_d;
    rm_q       <= rm_d;
    hoff_q     <= hoff_d;
    colp_q     <= colp_d;
    tmp_q      <= tmp_d;
    pg_q       <= pg_d;
    rr_q       <= rr_d;
    lr_q       <= lr_d;
    fc_q       <= fc_d;
    rows_q     <= rows_d;
    whole_q    <= whole_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !whole_q) |-> (6'(lr_q) < rows_q))
    else $error("row counter past row count");

  a_last_ends_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && emit_last) |=> (state_q == ST_IDLE))
    else $error("sequencer kept running after last burst");

  a_div_free_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_head_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && func_q) |-> (8'(rm_q) < 8'(hc)))
    else $error("interleaved head remainder out of range");
`endif

endmodule
